// ----- hw/rtl/quad_pair_sat_collision_defines.svh -----
// Assertion macros shared by the quad pair collision RTL.
// Files that check their own logic include this header; it needs clk and rst_n in scope.
`ifndef QUAD_PAIR_SAT_COLLISION_DEFINES_SVH
`define QUAD_PAIR_SAT_COLLISION_DEFINES_SVH

// Check at every edge outside reset.
`define QPSC_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define QPSC_CHECK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/qpsc_pkg.sv -----
// Shared types and constants for the quad pair separating-axis collision block.
// No dependencies; used by qpsc_front, qpsc_engine and the top level.
package qpsc_pkg;

  localparam int COORD_W_DEF = 24;
  localparam int GAIN_W      = 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd19661;
  localparam logic [2:0] TRIG_SLOT = 3'd7;
  localparam int FIFO_DEPTH  = 4;

  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 33;
  localparam int NORM_W  = 18;
  localparam int MAG_W   = 31;
  localparam int ROOT_W  = 32;

  typedef struct packed {
    logic       trig;
    logic [2:0] slot;
  } qpsc_tag_t;

endpackage

// ----- hw/rtl/qpsc_front.sv -----
// Front end: accepts vertex words, tags the trigger slot and queues them.
// Depends on qpsc_pkg and the assertion macro header.
`include "quad_pair_sat_collision_defines.svh"

module qpsc_front import qpsc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF,
  parameter int DEPTH       = FIFO_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_vertex_slot,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  output logic                          q_valid,
  output qpsc_tag_t                     q_tag,
  output logic signed [COORD_WIDTH-1:0] q_x,
  output logic signed [COORD_WIDTH-1:0] q_y,
  input  logic                          q_pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  qpsc_tag_t                     tag_mem_r [DEPTH];
  logic signed [COORD_WIDTH-1:0] x_mem_r   [DEPTH];
  logic signed [COORD_WIDTH-1:0] y_mem_r   [DEPTH];
  logic [PTR_W-1:0]              wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          push, pop;
  qpsc_tag_t                     in_tag;

  assign in_ready = (cnt_r < CNT_W'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;

  assign in_tag.trig = (in_vertex_slot == TRIG_SLOT);
  assign in_tag.slot = in_vertex_slot;

  assign q_tag = tag_mem_r[rd_ptr_r];
  assign q_x   = x_mem_r[rd_ptr_r];
  assign q_y   = y_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      tag_mem_r[wr_ptr_r] <= in_tag;
      x_mem_r[wr_ptr_r]   <= in_vertex_x;
      y_mem_r[wr_ptr_r]   <= in_vertex_y;
    end
  end

  `QPSC_CHECK(a_fifo_fill, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1), "queue fill lost")
  `QPSC_CHECK(a_fifo_drain, (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1), "queue drain lost")
  `QPSC_CHECK(a_pop_nonempty, q_pop |-> q_valid, "pop from empty queue")

endmodule

// ----- hw/rtl/qpsc_engine.sv -----
// Back end: vertex store, separating-axis sequencer with shared multiplier,
// root and divide steps, and the result register. Depends on qpsc_pkg and macros.
`include "quad_pair_sat_collision_defines.svh"

module qpsc_engine import qpsc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  qpsc_tag_t                     q_tag,
  input  logic signed [COORD_WIDTH-1:0] q_x,
  input  logic signed [COORD_WIDTH-1:0] q_y,
  output logic                          q_pop,
  input  logic                          cfg_valid,
  input  logic [GAIN_W-1:0]             cfg_push_gain,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_overlap,
  output logic signed [COORD_WIDTH-1:0] out_push_x,
  output logic signed [COORD_WIDTH-1:0] out_push_y
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 18;
  localparam int L8W  = W + 2;
  localparam int PRW  = W + 19;
  localparam int SR_W = 36;
  localparam int QB   = 17;
  localparam int DV_W = MAG_W + QB;
  localparam int MP_W = MUL_A_W + MUL_B_W;

  localparam logic [1:0] PH_MX  = 2'd0;
  localparam logic [1:0] PH_MY  = 2'd1;
  localparam logic [1:0] PH_SUM = 2'd2;
  localparam logic [1:0] PH_CMP = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_LDF, S_LDT, S_SQA, S_SQB, S_SQRT, S_DIVY, S_DIVX, S_PROJ,
    S_TEST, S_G1, S_G2, S_L8, S_FX, S_FY, S_FS, S_OUT
  } state_t;

  state_t                   state_r;
  logic [2:0]               axis_r, vidx_r, rd_idx;
  logic [1:0]               pph_r;
  logic [4:0]               it_r;
  logic [GAIN_W-1:0]        gain_r;
  logic signed [W-1:0]      vx_r [8];
  logic signed [W-1:0]      vy_r [8];
  logic signed [W-1:0]      fx_r, fy_r, rd_x, rd_y;
  logic [MAG_W-1:0]         a_r, b_r;
  logic                     dx_neg_r, dy_pos_r;
  logic [63:0]              sum_r;
  logic [SR_W-1:0]          rem_r;
  logic [ROOT_W-1:0]        root_r;
  logic [DV_W-1:0]          dv_rem_r, dv_d_r;
  logic [QB-1:0]            q_r, qy_r;
  logic signed [NORM_W-1:0] nx_r, ny_r, bnx_r, bny_r;
  logic signed [DW-1:0]     pa_r, pb_r, p_r, mina_r, maxa_r, minb_r, maxb_r;
  logic [DW-1:0]            depth_r, g1_r, blen_r;
  logic [L8W-1:0]           len8_r;
  logic signed [PRW-1:0]    prod_r;
  logic                     ovl_r;
  logic signed [W-1:0]      px_r, py_r;
  logic                     out_valid_r, out_ovl_r;
  logic signed [W-1:0]      out_px_r, out_py_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MP_W-1:0]    mul_p;

  logic signed [W:0]  dx, dy;
  logic [W:0]         ax, ay;
  logic [33:0]        mx34;
  logic [1:0]         sh;
  logic [MAG_W-1:0]   a_nxt, b_nxt;

  logic [SR_W-1:0]    rem_sh, trial, rem_step;
  logic               sq_ge;
  logic [ROOT_W-1:0]  root_step;

  logic               dv_ge;
  logic [DV_W-1:0]    dv_rem_step;
  logic [QB-1:0]      q_step;

  logic signed [DW:0] da, db;
  logic               sep;
  logic [DW-1:0]      len_nxt;
  logic [DW:0]        l8_sum;
  logic               first;

  function automatic logic signed [W-1:0] rnd_sat(input logic signed [PRW-1:0] v);
    logic [PRW-1:0] mag;
    logic [PRW-1:0] r;
    logic [PRW-1:0] lim;
    logic [PRW-1:0] nr;
    logic signed [W-1:0] res;
    mag = v[PRW-1] ? PRW'(-v) : PRW'(v);
    r   = (mag + PRW'(32768)) >> 16;
    lim = PRW'(1) << (W - 1);
    nr  = PRW'(-r);
    if (!v[PRW-1]) begin
      res = (r >= lim) ? {1'b0, {(W-1){1'b1}}} : r[W-1:0];
    end else begin
      res = (r > lim) ? {1'b1, {(W-1){1'b0}}} : nr[W-1:0];
    end
    return res;
  endfunction

  assign q_pop       = (state_r == S_IDLE) && q_valid;
  assign out_valid   = out_valid_r;
  assign out_overlap = out_ovl_r;
  assign out_push_x  = out_px_r;
  assign out_push_y  = out_py_r;

  always_comb begin
    unique case (state_r)
      S_LDF:   rd_idx = axis_r;
      S_LDT:   rd_idx = {axis_r[2], axis_r[1:0] + 2'd1};
      default: rd_idx = vidx_r;
    endcase
  end

  assign rd_x = vx_r[rd_idx];
  assign rd_y = vy_r[rd_idx];

  always_comb begin
    dx   = rd_x - fx_r;
    dy   = rd_y - fy_r;
    ax   = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
    ay   = dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
    mx34 = 34'(ax | ay);
    if (mx34 >= 34'h1_0000_0000) begin
      sh = 2'd2;
    end else if (mx34 >= 34'h0_8000_0000) begin
      sh = 2'd1;
    end else begin
      sh = 2'd0;
    end
    a_nxt = MAG_W'(34'(ax) >> sh);
    b_nxt = MAG_W'(34'(ay) >> sh);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQA: begin
        mul_a = MUL_A_W'(a_r);
        mul_b = MUL_B_W'(a_r);
      end
      S_SQB: begin
        mul_a = MUL_A_W'(b_r);
        mul_b = MUL_B_W'(b_r);
      end
      S_PROJ: begin
        mul_a = (pph_r == PH_MX) ? MUL_A_W'(rd_x) : MUL_A_W'(rd_y);
        mul_b = (pph_r == PH_MX) ? MUL_B_W'(nx_r) : MUL_B_W'(ny_r);
      end
      S_G1: begin
        mul_a = MUL_A_W'(depth_r[DW-1:16]);
        mul_b = MUL_B_W'(gain_r);
      end
      S_G2: begin
        mul_a = MUL_A_W'(depth_r[15:0]);
        mul_b = MUL_B_W'(gain_r);
      end
      S_FX: begin
        mul_a = MUL_A_W'(len8_r);
        mul_b = MUL_B_W'(bnx_r);
      end
      S_FY: begin
        mul_a = MUL_A_W'(len8_r);
        mul_b = MUL_B_W'(bny_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    rem_sh    = {rem_r[SR_W-3:0], sum_r[63:62]};
    trial     = SR_W'({root_r, 2'b01});
    sq_ge     = (rem_sh >= trial);
    rem_step  = sq_ge ? rem_sh - trial : rem_sh;
    root_step = {root_r[ROOT_W-2:0], sq_ge};

    dv_ge       = (dv_rem_r >= dv_d_r);
    dv_rem_step = dv_ge ? dv_rem_r - dv_d_r : dv_rem_r;
    q_step      = {q_r[QB-2:0], dv_ge};

    da      = maxa_r - minb_r;
    db      = maxb_r - mina_r;
    sep     = (maxa_r <= minb_r) || (maxb_r <= mina_r);
    len_nxt = g1_r + DW'(mul_p[31:16]);
    l8_sum  = {1'b0, blen_r} + (DW+1)'(32768);
    first   = (vidx_r[1:0] == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gain_r      <= GAIN_RESET;
    end else begin
      if (cfg_valid) begin
        gain_r <= cfg_push_gain;
      end
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            vx_r[q_tag.slot] <= q_x;
            vy_r[q_tag.slot] <= q_y;
            if (q_tag.trig) begin
              axis_r  <= 3'd0;
              state_r <= S_LDF;
            end
          end
        end
        S_LDF: begin
          fx_r    <= rd_x;
          fy_r    <= rd_y;
          state_r <= S_LDT;
        end
        S_LDT: begin
          a_r      <= a_nxt;
          b_r      <= b_nxt;
          dx_neg_r <= dx[W];
          dy_pos_r <= !dy[W] && (dy != '0);
          state_r  <= S_SQA;
        end
        S_SQA: begin
          sum_r   <= {2'b00, mul_p[61:0]};
          state_r <= S_SQB;
        end
        S_SQB: begin
          sum_r   <= sum_r + {2'b00, mul_p[61:0]};
          rem_r   <= '0;
          root_r  <= '0;
          it_r    <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          rem_r  <= rem_step;
          root_r <= root_step;
          sum_r  <= {sum_r[61:0], 2'b00};
          if (it_r == 5'd31) begin
            if (root_step == '0) begin
              ovl_r   <= 1'b0;
              px_r    <= '0;
              py_r    <= '0;
              state_r <= S_OUT;
            end else begin
              dv_rem_r <= DV_W'({b_r, 16'h0000}) + DV_W'(root_step >> 1);
              dv_d_r   <= DV_W'({root_step, 16'h0000});
              q_r      <= '0;
              it_r     <= '0;
              state_r  <= S_DIVY;
            end
          end else begin
            it_r <= it_r + 1'b1;
          end
        end
        S_DIVY: begin
          if (it_r == 5'(QB - 1)) begin
            qy_r     <= q_step;
            dv_rem_r <= DV_W'({a_r, 16'h0000}) + DV_W'(root_r >> 1);
            dv_d_r   <= DV_W'({root_r, 16'h0000});
            q_r      <= '0;
            it_r     <= '0;
            state_r  <= S_DIVX;
          end else begin
            dv_rem_r <= dv_rem_step;
            dv_d_r   <= dv_d_r >> 1;
            q_r      <= q_step;
            it_r     <= it_r + 1'b1;
          end
        end
        S_DIVX: begin
          if (it_r == 5'(QB - 1)) begin
            nx_r    <= dy_pos_r ? -$signed({1'b0, qy_r}) : $signed({1'b0, qy_r});
            ny_r    <= dx_neg_r ? -$signed({1'b0, q_step}) : $signed({1'b0, q_step});
            vidx_r  <= 3'd0;
            pph_r   <= PH_MX;
            state_r <= S_PROJ;
          end else begin
            dv_rem_r <= dv_rem_step;
            dv_d_r   <= dv_d_r >> 1;
            q_r      <= q_step;
            it_r     <= it_r + 1'b1;
          end
        end
        S_PROJ: begin
          pph_r <= pph_r + 1'b1;
          case (pph_r)
            PH_MX:  pa_r <= DW'(mul_p);
            PH_MY:  pb_r <= DW'(mul_p);
            PH_SUM: p_r  <= pa_r + pb_r;
            default: begin
              if (!vidx_r[2]) begin
                if (first || p_r < mina_r) mina_r <= p_r;
                if (first || p_r > maxa_r) maxa_r <= p_r;
              end else begin
                if (first || p_r < minb_r) minb_r <= p_r;
                if (first || p_r > maxb_r) maxb_r <= p_r;
              end
              vidx_r <= vidx_r + 1'b1;
              if (vidx_r == 3'd7) begin
                state_r <= S_TEST;
              end
            end
          endcase
        end
        S_TEST: begin
          if (sep) begin
            ovl_r   <= 1'b0;
            px_r    <= '0;
            py_r    <= '0;
            state_r <= S_OUT;
          end else begin
            if (da < db) begin
              depth_r <= da[DW-1:0];
            end else begin
              depth_r <= db[DW-1:0];
              nx_r    <= -nx_r;
              ny_r    <= -ny_r;
            end
            state_r <= S_G1;
          end
        end
        S_G1: begin
          g1_r    <= DW'(mul_p);
          state_r <= S_G2;
        end
        S_G2: begin
          if (axis_r == 3'd0 || len_nxt < blen_r) begin
            blen_r <= len_nxt;
            bnx_r  <= nx_r;
            bny_r  <= ny_r;
          end
          axis_r <= axis_r + 1'b1;
          if (axis_r == 3'd7) begin
            state_r <= S_L8;
          end else begin
            state_r <= S_LDF;
          end
        end
        S_L8: begin
          len8_r  <= l8_sum[L8W+15:16];
          state_r <= S_FX;
        end
        S_FX: begin
          prod_r  <= PRW'(mul_p);
          state_r <= S_FY;
        end
        S_FY: begin
          px_r    <= rnd_sat(prod_r);
          prod_r  <= PRW'(mul_p);
          state_r <= S_FS;
        end
        S_FS: begin
          py_r    <= rnd_sat(prod_r);
          ovl_r   <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_ovl_r   <= ovl_r;
            out_px_r    <= px_r;
            out_py_r    <= py_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `QPSC_CHECK(a_result_load, (state_r == S_OUT && (!out_valid_r || out_ready)) |=> out_valid_r, "result not loaded")
  `QPSC_CHECK(a_sep_zero, (out_valid_r && !out_overlap) |-> (out_push_x == '0 && out_push_y == '0), "push on no overlap")
  `QPSC_CHECK_RST(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset left block busy")

endmodule

// ----- hw/rtl/quad_pair_sat_collision.sv -----
// Top level of the quad pair separating-axis collision block.
// Instantiates qpsc_front and qpsc_engine; uses qpsc_pkg.
//
// Usage:
//   Input words (in_valid/in_ready) carry one vertex each: slots 0..3 are the
//   corners of quad A, 4..7 those of quad B. A word for slot 7 runs the test.
//   Result words (out_valid/out_ready) carry the overlap flag and the push
//   vector; only slot 7 words make one. cfg_valid/cfg_ready write push_gain
//   and are always ready; the user must write it only while the block is
//   idle, which the block itself does not enforce. A front queue of four
//   words takes input at one word per cycle while it has room. The test runs
//   on one shared multiplier, a one-bit-per-cycle root and a one-bit-per-cycle
//   divider; it ends at the first axis that separates, else runs all eight.
//   Results leave through an output register; when the receiver stalls the
//   engine holds its finished result and the queue fills, then in_ready drops.
//   Reset empties the queue, clears the result valid flag and sets push_gain to
//   0.3; the vertex store holds no value until written.
module quad_pair_sat_collision import qpsc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_vertex_slot,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_overlap,
  output logic signed [COORD_WIDTH-1:0] out_push_x,
  output logic signed [COORD_WIDTH-1:0] out_push_y,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [GAIN_W-1:0]             cfg_push_gain
);

  logic                          q_valid, q_pop;
  qpsc_tag_t                     q_tag;
  logic signed [COORD_WIDTH-1:0] q_x, q_y;

  assign cfg_ready = 1'b1;

  qpsc_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .DEPTH       (FIFO_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_vertex_slot (in_vertex_slot),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .q_valid        (q_valid),
    .q_tag          (q_tag),
    .q_x            (q_x),
    .q_y            (q_y),
    .q_pop          (q_pop)
  );

  qpsc_engine #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_tag         (q_tag),
    .q_x           (q_x),
    .q_y           (q_y),
    .q_pop         (q_pop),
    .cfg_valid     (cfg_valid),
    .cfg_push_gain (cfg_push_gain),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_overlap   (out_overlap),
    .out_push_x    (out_push_x),
    .out_push_y    (out_push_y)
  );

endmodule
